### hw/rtl/mhf_pkg.sv
// Package for the mask hole filler: sizes, register indexes, shared types and side clamping.
package mhf_pkg;

  // Largest mask side that the line memories hold
  localparam int unsigned MAX_SIDE   = 4096;
  localparam int unsigned MIN_SIDE   = 3;
  localparam int unsigned SIDE_W     = $clog2(MAX_SIDE + 1);
  localparam int unsigned POS_W      = $clog2(MAX_SIDE);
  localparam int unsigned ROW_W      = $clog2(MAX_SIDE + 2);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned THR_W      = 4;
  localparam int unsigned CNT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FILL_MIN = CFG_IDX_W'(1);

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(2048);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(5);

  // Per-transaction control into the window
  typedef struct packed {
    logic shift;
    logic interior;
    logic pix;
  } mhf_win_ctrl_t;

  // One result transaction
  typedef struct packed {
    logic pixel_out;
    logic filled;
    logic last;
  } mhf_res_t;

  // Clamp a written side to the supported range
  function automatic logic [SIDE_W-1:0] clamp_side(logic [CFG_DATA_W-1:0] raw);
    logic [SIDE_W-1:0] res;
    if (32'(raw) < MIN_SIDE) begin
      res = SIDE_W'(MIN_SIDE);
    end else if (32'(raw) > MAX_SIDE) begin
      res = SIDE_W'(MAX_SIDE);
    end else begin
      res = SIDE_W'(raw);
    end
    return res;
  endfunction

endpackage

### hw/rtl/mhf_line_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mhf_line_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 1,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mhf_window.sv
// 3x3 neighbourhood window and fill decision for the hole filler.
module mhf_window (
  input  logic                        clk_i,
  input  mhf_pkg::mhf_win_ctrl_t      ctrl_i,
  input  logic                        top_new_i,
  input  logic                        mid_new_i,
  input  logic [mhf_pkg::THR_W-1:0]   thr_i,
  output logic                        pixel_out_o,
  output logic                        filled_o
);
  import mhf_pkg::*;

  // Top row holds filled values, middle left is the previous result,
  // middle centre and right and the bottom row are as received
  logic t0_q, t1_q;
  logic m0_q, m1_q;
  logic b0_q, b1_q;
  logic [CNT_W-1:0] count;
  logic             fill;

  // Count set neighbours
  always_comb begin
    count = CNT_W'(t0_q) + CNT_W'(t1_q) + CNT_W'(top_new_i)
          + CNT_W'(m0_q) + CNT_W'(mid_new_i)
          + CNT_W'(b0_q) + CNT_W'(b1_q) + CNT_W'(ctrl_i.pix);
  end

  // Fill an interior zero pixel with enough set neighbours
  assign fill        = ~m1_q & ctrl_i.interior & (count >= thr_i);
  assign filled_o    = fill;
  assign pixel_out_o = m1_q | fill;

  // Advance the window on each transaction
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      t0_q <= t1_q;
      t1_q <= top_new_i;
      m0_q <= m1_q | fill;
      m1_q <= mid_new_i;
      b0_q <= b1_q;
      b1_q <= ctrl_i.pix;
    end
  end

endmodule

### hw/rtl/mhf_out_buf.sv
// Output register with skid stage for result transactions.
module mhf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mhf_pkg::mhf_res_t push_data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  output mhf_pkg::mhf_res_t out_data_o,
  input  logic              out_ready_i
);
  import mhf_pkg::*;

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  mhf_res_t out_data_q, out_data_d;
  mhf_res_t skid_data_q, skid_data_d;
  logic     out_free;

  assign out_free = ~out_valid_q | out_ready_i;
  assign ready_o  = ~skid_valid_q;

  // Move skid into the output stage when it drains, else park new results
  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q | push_i;
      out_data_d   = skid_valid_q ? skid_data_q : push_data_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hw/rtl/mask_hole_fill_top.sv
// Top level of the streaming mask hole filler.
// Throughput: one pixel transaction per cycle while the output buffer can take it;
// each line memory takes one write and one read per cycle. The result for a
// pixel enters the output buffer with the transaction side+1 positions later; side+1
// pad transactions flush a frame. Reset clears the counters and output stages and loads
// side 2048 and threshold 5; line memory contents stay undefined and need no clearing.
module mask_hole_fill_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             pixel_i,
  input  logic                             pad_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             pixel_out_o,
  output logic                             filled_o,
  output logic                             last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mhf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mhf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mhf_pkg::*;

  // Configuration registers
  logic [SIDE_W-1:0] side_q;
  logic [POS_W-1:0]  side_m1_q, side_m2_q;
  logic [THR_W-1:0]  thr_q;

  // Position counters
  logic [ROW_W-1:0]  in_row_q, in_row_d;
  logic [POS_W-1:0]  in_col_q, in_col_d;
  logic [POS_W-1:0]  out_row_q, out_row_d;
  logic [POS_W-1:0]  out_col_q, out_col_d;
  logic              active_q, active_d;

  logic              cfg_acc, side_wr, in_acc;
  logic              beyond, pix_eff, last_pos, frame_done, interior;
  logic              mid_new, top_new;
  logic              win_pixel, win_filled;
  logic              buf_ready;
  mhf_win_ctrl_t     win_ctrl;
  mhf_res_t          res, out_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  assign side_wr     = cfg_acc & (cfg_index_i == REG_SIDE);

  assign in_ready_o  = buf_ready;
  assign in_acc      = in_valid_i & in_ready_o;

  // Pixels past the frame and pads enter as zero
  assign beyond   = in_row_q >= ROW_W'(side_q);
  assign pix_eff  = pixel_i & ~pad_i & ~beyond;

  assign last_pos   = (out_row_q == side_m1_q) & (out_col_q == side_m1_q);
  assign frame_done = in_acc & active_q & last_pos;
  assign interior   = (out_row_q != '0) & (out_row_q <= side_m2_q)
                    & (out_col_q != '0) & (out_col_q <= side_m2_q);

  // Advance the input and output positions; restart at frame end or side write
  always_comb begin
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    active_d  = active_q;
    if (side_wr || frame_done) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
      active_d  = 1'b0;
    end else if (in_acc) begin
      if (in_col_q == side_m1_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + POS_W'(1);
      end
      if (in_row_q == ROW_W'(1) && in_col_q == '0) begin
        active_d = 1'b1;
      end
      if (active_q) begin
        if (out_col_q == side_m1_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + POS_W'(1);
        end else begin
          out_col_d = out_col_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      active_q  <= 1'b0;
    end else begin
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      active_q  <= active_d;
    end
  end

  // Hold configuration, with side stored clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= SIDE_RESET;
      side_m1_q <= POS_W'(SIDE_RESET - SIDE_W'(1));
      side_m2_q <= POS_W'(SIDE_RESET - SIDE_W'(2));
      thr_q     <= THR_RESET;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        REG_SIDE: begin
          side_q    <= clamp_side(cfg_data_i);
          side_m1_q <= POS_W'(clamp_side(cfg_data_i) - SIDE_W'(1));
          side_m2_q <= POS_W'(clamp_side(cfg_data_i) - SIDE_W'(2));
        end
        REG_FILL_MIN: begin
          thr_q <= cfg_data_i[THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Line of received pixels, read one row later at the same column
  mhf_line_ram #(
    .DEPTH (MAX_SIDE),
    .WIDTH (1)
  ) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc & ~frame_done),
    .waddr_i (in_col_q),
    .wdata_i (pix_eff),
    .raddr_i (in_col_d),
    .rdata_o (mid_new)
  );

  // Line of filled results, feeding the row above
  mhf_line_ram #(
    .DEPTH (MAX_SIDE),
    .WIDTH (1)
  ) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc & active_q),
    .waddr_i (out_col_q),
    .wdata_i (win_pixel),
    .raddr_i (in_col_d),
    .rdata_o (top_new)
  );

  // Neighbourhood window and decision
  assign win_ctrl.shift    = in_acc;
  assign win_ctrl.interior = interior;
  assign win_ctrl.pix      = pix_eff;

  mhf_window u_window (
    .clk_i       (clk_i),
    .ctrl_i      (win_ctrl),
    .top_new_i   (top_new),
    .mid_new_i   (mid_new),
    .thr_i       (thr_q),
    .pixel_out_o (win_pixel),
    .filled_o    (win_filled)
  );

  assign res.pixel_out = win_pixel;
  assign res.filled    = win_filled;
  assign res.last      = last_pos;

  // Buffer results towards the output channel
  mhf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc & active_q),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_res),
    .out_ready_i (out_ready_i)
  );

  assign pixel_out_o = out_res.pixel_out;
  assign filled_o    = out_res.filled;
  assign last_o      = out_res.last;

endmodule
